// ===== hdl/weighted_queue_share_allocator_assert.svh =====
// Assertion macros for the weighted queue share allocator checker.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef WEIGHTED_QUEUE_SHARE_ALLOCATOR_ASSERT_SVH
`define WEIGHTED_QUEUE_SHARE_ALLOCATOR_ASSERT_SVH

// Property checked outside of reset
`define WQSA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wqsa assertion failed");

// Property that also holds across reset
`define WQSA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("wqsa assertion failed during reset");

`endif

// ===== hdl/wqsa_pkg.sv =====
// Shared constants, register codes, controller states and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package wqsa_pkg;

  localparam int NUM_QUEUES      = 4;
  localparam int SLOTS_PER_QUEUE = 4;
  localparam int AMOUNT_BITS     = 16;

  localparam int QUEUE_W   = 2;
  localparam int SLOT_W    = 2;
  localparam int CNT_W     = $clog2(SLOTS_PER_QUEUE + 1);
  localparam int NUM_SLOTS = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WEIGHT_W  = 8;
  localparam int SUM_W     = WEIGHT_W + $clog2(NUM_QUEUES);
  localparam int PROD_W    = WEIGHT_W + AMOUNT_BITS;
  localparam int DIV_CNT_W = $clog2(PROD_W);
  localparam int RR_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL   = 3'd0,
    REG_UNIT    = 3'd1,
    REG_WEIGHT0 = 3'd2,
    REG_WEIGHT1 = 3'd3,
    REG_WEIGHT2 = 3'd4,
    REG_WEIGHT3 = 3'd5,
    REG_RR_MASK = 3'd6
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SETUP,
    ST_VISIT,
    ST_NEXT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic append;     // store a job
    logic tick_init;  // latch weight sum and unit, start at queue 0
    logic mul;        // weight * total
    logic div_start;  // start quota division
    logic setup;      // latch quota, loaded count, start slot
    logic visit;      // serve one slot
    logic next_q;     // advance to the next queue
    logic finish;     // push the closing record
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic queue_skip;  // empty queue or zero quota
    logic visit_ok;    // the visit can proceed (record space available)
    logic visit_more;  // the queue continues after this visit
    logic last_queue;
    logic finish_ok;   // output register free for the closing record
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/wqsa_div.sv =====
// Restoring divider, one quotient bit per cycle, for the per-queue quota.
// Depends on wqsa_pkg for widths.
`default_nettype none

module wqsa_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [wqsa_pkg::PROD_W-1:0]  dividend,
  input  wire logic [wqsa_pkg::SUM_W-1:0]   divisor,
  output logic                              done,
  output logic [wqsa_pkg::PROD_W-1:0]       quotient
);

  logic                           busy;
  logic [wqsa_pkg::DIV_CNT_W-1:0] cnt;
  logic [wqsa_pkg::SUM_W-1:0]     rem;
  logic [wqsa_pkg::PROD_W-1:0]    quo;
  logic [wqsa_pkg::SUM_W:0]       trial;
  logic [wqsa_pkg::SUM_W:0]       diff;
  logic                           ge;
  logic [wqsa_pkg::SUM_W-1:0]     step_rem;

  // One trial subtraction
  always_comb begin
    trial    = {rem, quo[wqsa_pkg::PROD_W-1]};
    ge       = (trial >= {1'b0, divisor});
    diff     = trial - {1'b0, divisor};
    step_rem = ge ? diff[wqsa_pkg::SUM_W-1:0] : trial[wqsa_pkg::SUM_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == wqsa_pkg::DIV_CNT_W'(wqsa_pkg::PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Shift register: dividend in, quotient out
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= step_rem;
      quo <= {quo[wqsa_pkg::PROD_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ===== hdl/wqsa_ctrl.sv =====
// Tick sequencer: walks the queues through multiply, divide and slot visits.
// Depends on wqsa_pkg for state, command and status types.
`default_nettype none

module wqsa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              action,
  output logic                   in_ready,
  input  wire wqsa_pkg::status_t status,
  output wqsa_pkg::cmd_t         cmd
);

  wqsa_pkg::state_t state;
  wqsa_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wqsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      wqsa_pkg::ST_IDLE: begin
        if (in_valid && action) state_next = wqsa_pkg::ST_MUL;
      end
      wqsa_pkg::ST_MUL:     state_next = wqsa_pkg::ST_DIV_GO;
      wqsa_pkg::ST_DIV_GO:  state_next = wqsa_pkg::ST_DIV_WAIT;
      wqsa_pkg::ST_DIV_WAIT: begin
        if (status.div_done) state_next = wqsa_pkg::ST_SETUP;
      end
      wqsa_pkg::ST_SETUP: begin
        state_next = status.queue_skip ? wqsa_pkg::ST_NEXT : wqsa_pkg::ST_VISIT;
      end
      wqsa_pkg::ST_VISIT: begin
        if (status.visit_ok && !status.visit_more) state_next = wqsa_pkg::ST_NEXT;
      end
      wqsa_pkg::ST_NEXT: begin
        state_next = status.last_queue ? wqsa_pkg::ST_FINISH : wqsa_pkg::ST_MUL;
      end
      wqsa_pkg::ST_FINISH: begin
        if (status.finish_ok) state_next = wqsa_pkg::ST_IDLE;
      end
      default: state_next = wqsa_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      wqsa_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.append    = in_valid && !action;
        cmd.tick_init = in_valid && action;
      end
      wqsa_pkg::ST_MUL:      cmd.mul       = 1'b1;
      wqsa_pkg::ST_DIV_GO:   cmd.div_start = 1'b1;
      wqsa_pkg::ST_DIV_WAIT: cmd           = '0;
      wqsa_pkg::ST_SETUP:    cmd.setup     = 1'b1;
      wqsa_pkg::ST_VISIT:    cmd.visit     = status.visit_ok;
      wqsa_pkg::ST_NEXT:     cmd.next_q    = !status.last_queue;
      wqsa_pkg::ST_FINISH:   cmd.finish    = status.finish_ok;
      default:               cmd           = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/wqsa_dp.sv =====
// Datapath: configuration registers, job stores, quota arithmetic, slot
// service and the record pipeline. Depends on wqsa_pkg and wqsa_div.
`default_nettype none

module wqsa_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire wqsa_pkg::cmd_t                        cmd,
  output wqsa_pkg::status_t                          status,
  input  wire logic                                  cfg_write,
  input  wire logic [wqsa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [wqsa_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic [wqsa_pkg::QUEUE_W-1:0]          queue_index,
  input  wire logic [wqsa_pkg::AMOUNT_BITS-1:0]      demand,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [wqsa_pkg::QUEUE_W-1:0]               granted_queue,
  output logic [wqsa_pkg::SLOT_W-1:0]                granted_slot,
  output logic [wqsa_pkg::AMOUNT_BITS-1:0]           amount,
  output logic                                       finished_now,
  output logic                                       nothing_given,
  output logic                                       last
);

  // Configuration
  logic [wqsa_pkg::AMOUNT_BITS-1:0] total_resource;
  logic [wqsa_pkg::AMOUNT_BITS-1:0] unit_size;
  logic [wqsa_pkg::WEIGHT_W-1:0]    weight [wqsa_pkg::NUM_QUEUES];
  logic [wqsa_pkg::RR_W-1:0]        rr_mask;

  // Job state
  logic [wqsa_pkg::AMOUNT_BITS-1:0] remaining_work [wqsa_pkg::NUM_SLOTS];
  logic [wqsa_pkg::NUM_SLOTS-1:0]   job_done;
  logic [wqsa_pkg::CNT_W-1:0]       jobs_loaded [wqsa_pkg::NUM_QUEUES];
  logic [wqsa_pkg::SLOT_W-1:0]      rotation_position [wqsa_pkg::NUM_QUEUES];

  // Tick working registers
  logic [wqsa_pkg::SUM_W-1:0]       sum_w;
  logic [wqsa_pkg::AMOUNT_BITS-1:0] unit;
  logic [wqsa_pkg::QUEUE_W-1:0]     cur_q;
  logic [wqsa_pkg::PROD_W-1:0]      product;
  logic [wqsa_pkg::AMOUNT_BITS-1:0] quota;
  logic [wqsa_pkg::CNT_W-1:0]       n_jobs;
  logic [wqsa_pkg::SLOT_W-1:0]      pos;
  logic [wqsa_pkg::CNT_W-1:0]       served;
  logic                             is_rr;

  // Pending record (held back until its successor shows whether it is last)
  logic                             pend_valid;
  logic [wqsa_pkg::QUEUE_W-1:0]     pend_queue;
  logic [wqsa_pkg::SLOT_W-1:0]      pend_slot;
  logic [wqsa_pkg::AMOUNT_BITS-1:0] pend_amount;
  logic                             pend_fin;

  // Combinational helpers
  logic [wqsa_pkg::SUM_W-1:0]       sum_comb;
  logic                             div_done;
  logic [wqsa_pkg::PROD_W-1:0]      div_quo;
  logic [wqsa_pkg::AMOUNT_BITS-1:0] quota_src;
  logic [wqsa_pkg::CNT_W-1:0]       n_src;
  logic [wqsa_pkg::SLOT_W-1:0]      rot_cur;
  logic [wqsa_pkg::SLOT_W-1:0]      pos_src;
  logic [wqsa_pkg::IDX_W-1:0]       app_idx;
  logic                             app_ok;
  logic [wqsa_pkg::IDX_W-1:0]       vis_idx;
  logic [wqsa_pkg::AMOUNT_BITS-1:0] rem_cur;
  logic                             grant;
  logic [wqsa_pkg::AMOUNT_BITS-1:0] amt_unit;
  logic [wqsa_pkg::AMOUNT_BITS-1:0] amt;
  logic [wqsa_pkg::AMOUNT_BITS-1:0] rem_new;
  logic [wqsa_pkg::AMOUNT_BITS-1:0] quota_new;
  logic [wqsa_pkg::CNT_W-1:0]       pos_inc;
  logic [wqsa_pkg::SLOT_W-1:0]      pos_new;
  logic [wqsa_pkg::CNT_W-1:0]       served_new;
  logic                             more;
  logic                             push_ok;
  logic                             finish_ok;
  logic                             load_out;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      total_resource <= wqsa_pkg::AMOUNT_BITS'(100);
      unit_size      <= wqsa_pkg::AMOUNT_BITS'(10);
      rr_mask        <= '0;
      for (int q = 0; q < wqsa_pkg::NUM_QUEUES; q++) begin
        weight[q] <= '0;
      end
    end else if (cfg_write) begin
      case (wqsa_pkg::cfg_reg_t'(cfg_index))
        wqsa_pkg::REG_TOTAL:   total_resource <= cfg_data[wqsa_pkg::AMOUNT_BITS-1:0];
        wqsa_pkg::REG_UNIT:    unit_size      <= cfg_data[wqsa_pkg::AMOUNT_BITS-1:0];
        wqsa_pkg::REG_WEIGHT0: weight[0]      <= cfg_data[wqsa_pkg::WEIGHT_W-1:0];
        wqsa_pkg::REG_WEIGHT1: weight[1]      <= cfg_data[wqsa_pkg::WEIGHT_W-1:0];
        wqsa_pkg::REG_WEIGHT2: weight[2]      <= cfg_data[wqsa_pkg::WEIGHT_W-1:0];
        wqsa_pkg::REG_WEIGHT3: weight[3]      <= cfg_data[wqsa_pkg::WEIGHT_W-1:0];
        wqsa_pkg::REG_RR_MASK: rr_mask        <= cfg_data[wqsa_pkg::RR_W-1:0];
        default: ;
      endcase
    end
  end

  // Weight sum
  always_comb begin
    sum_comb = '0;
    for (int q = 0; q < wqsa_pkg::NUM_QUEUES; q++) begin
      sum_comb = sum_comb + wqsa_pkg::SUM_W'(weight[q]);
    end
  end

  // Quota divider: weight * total / sum of weights
  wqsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (sum_w),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Queue setup values
  always_comb begin
    quota_src = (sum_w == '0) ? '0 : div_quo[wqsa_pkg::AMOUNT_BITS-1:0];
    n_src     = jobs_loaded[cur_q];
    rot_cur   = rotation_position[cur_q];
    if (rr_mask[cur_q] && ({1'b0, rot_cur} < n_src)) begin
      pos_src = rot_cur;
    end else begin
      pos_src = '0;
    end
  end

  // Append address
  always_comb begin
    app_idx = wqsa_pkg::IDX_W'(int'(queue_index) * wqsa_pkg::SLOTS_PER_QUEUE
                               + int'(jobs_loaded[queue_index]));
    app_ok  = (int'(queue_index) < wqsa_pkg::NUM_QUEUES) && (demand != '0) &&
              (int'(jobs_loaded[queue_index]) < wqsa_pkg::SLOTS_PER_QUEUE);
  end

  // Slot service step
  always_comb begin
    vis_idx    = wqsa_pkg::IDX_W'(int'(cur_q) * wqsa_pkg::SLOTS_PER_QUEUE + int'(pos));
    rem_cur    = remaining_work[vis_idx];
    grant      = !job_done[vis_idx];
    amt_unit   = (rem_cur < unit) ? rem_cur : unit;
    amt        = (amt_unit < quota) ? amt_unit : quota;
    rem_new    = rem_cur - amt;
    quota_new  = grant ? (quota - amt) : quota;
    pos_inc    = {1'b0, pos} + 1'b1;
    served_new = served + 1'b1;
    if (is_rr) begin
      pos_new = (pos_inc == n_jobs) ? '0 : pos_inc[wqsa_pkg::SLOT_W-1:0];
      more    = (quota_new != '0) && (served_new < n_jobs);
    end else begin
      pos_new = pos_inc[wqsa_pkg::SLOT_W-1:0];
      more    = (pos_inc < n_jobs) && (quota_new != '0);
    end
  end

  // Record flow control
  always_comb begin
    push_ok   = !pend_valid || !out_valid || out_ready;
    finish_ok = !out_valid || out_ready;
    load_out  = (cmd.visit && grant && pend_valid) || cmd.finish;
  end

  // Status to controller
  always_comb begin
    status.div_done   = div_done;
    status.queue_skip = (n_src == '0) || (quota_src == '0);
    status.visit_ok   = !grant || push_ok;
    status.visit_more = more;
    status.last_queue = (int'(cur_q) == wqsa_pkg::NUM_QUEUES - 1);
    status.finish_ok  = finish_ok;
  end

  // Job store: work counts, no reset
  always_ff @(posedge clk) begin
    if (cmd.append && app_ok) begin
      remaining_work[app_idx] <= demand;
    end else if (cmd.visit && grant) begin
      remaining_work[vis_idx] <= rem_new;
    end
  end

  // Job flags, loaded counts and rotation positions
  always_ff @(posedge clk) begin
    if (rst) begin
      job_done <= '0;
      for (int q = 0; q < wqsa_pkg::NUM_QUEUES; q++) begin
        jobs_loaded[q]       <= '0;
        rotation_position[q] <= '0;
      end
    end else begin
      if (cmd.append && app_ok) begin
        job_done[app_idx]        <= 1'b0;
        jobs_loaded[queue_index] <= jobs_loaded[queue_index] + 1'b1;
      end
      if (cmd.visit && grant && (rem_new == '0)) begin
        job_done[vis_idx] <= 1'b1;
      end
      if (cmd.visit && is_rr && !more) begin
        rotation_position[cur_q] <= pos_new;
      end
    end
  end

  // Tick working registers
  always_ff @(posedge clk) begin
    if (cmd.tick_init) begin
      sum_w <= sum_comb;
      unit  <= (unit_size == '0) ? wqsa_pkg::AMOUNT_BITS'(1) : unit_size;
      cur_q <= '0;
    end else if (cmd.next_q) begin
      cur_q <= cur_q + 1'b1;
    end
    if (cmd.mul) begin
      product <= wqsa_pkg::PROD_W'(weight[cur_q]) * wqsa_pkg::PROD_W'(total_resource);
    end
    if (cmd.setup) begin
      quota  <= quota_src;
      n_jobs <= n_src;
      pos    <= pos_src;
      served <= '0;
      is_rr  <= rr_mask[cur_q];
    end else if (cmd.visit) begin
      quota  <= quota_new;
      pos    <= pos_new;
      served <= served_new;
    end
  end

  // Pending record valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.visit && grant) begin
      pend_valid <= 1'b1;
    end else if (cmd.finish) begin
      pend_valid <= 1'b0;
    end
  end

  // Pending record payload
  always_ff @(posedge clk) begin
    if (cmd.visit && grant) begin
      pend_queue  <= cur_q;
      pend_slot   <= pos;
      pend_amount <= amt;
      pend_fin    <= (rem_new == '0);
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload; closing record is either the pending grant or
  // the empty record of a grantless tick
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (pend_valid) begin
        granted_queue <= pend_queue;
        granted_slot  <= pend_slot;
        amount        <= pend_amount;
        finished_now  <= pend_fin;
        nothing_given <= 1'b0;
      end else begin
        granted_queue <= '0;
        granted_slot  <= '0;
        amount        <= '0;
        finished_now  <= 1'b0;
        nothing_given <= 1'b1;
      end
      last <= cmd.finish;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/weighted_queue_share_allocator.sv =====
// Top level of the weighted queue share allocator: sequencer plus datapath.
// Depends on wqsa_pkg, wqsa_ctrl, wqsa_dp (and wqsa_div below it).
`default_nettype none

// An append item (action 0) stores the job in the next free slot of its queue
// unless that queue is full or demand is zero; it produces no record. A tick
// item (action 1) shares total_resource among the four queues by weight and
// hands out grants of at most unit_size per job visit, one record per grant,
// with last set on the final record (a tick without grants gives one record
// with nothing_given set). Each queue's quota comes from the one-bit-per-cycle
// quota divider (start, 24 quotient bits, done), which dominates the tick
// length; a stalled output lengthens the tick further. The next item is taken
// right after the tick's final record has moved to the output register.
module weighted_queue_share_allocator (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  action,
  input  wire logic [wqsa_pkg::QUEUE_W-1:0]          queue_index,
  input  wire logic [wqsa_pkg::AMOUNT_BITS-1:0]      demand,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [wqsa_pkg::QUEUE_W-1:0]               granted_queue,
  output logic [wqsa_pkg::SLOT_W-1:0]                granted_slot,
  output logic [wqsa_pkg::AMOUNT_BITS-1:0]           amount,
  output logic                                       finished_now,
  output logic                                       nothing_given,
  output logic                                       last,
  input  wire logic                                  cfg_write,
  input  wire logic [wqsa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [wqsa_pkg::CFG_DATA_W-1:0]       cfg_data
);

  wqsa_pkg::cmd_t    cmd;
  wqsa_pkg::status_t status;

  // Sequencer
  wqsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  wqsa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .queue_index   (queue_index),
    .demand        (demand),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_queue (granted_queue),
    .granted_slot  (granted_slot),
    .amount        (amount),
    .finished_now  (finished_now),
    .nothing_given (nothing_given),
    .last          (last)
  );

endmodule

`default_nettype wire

// ===== hdl/wqsa_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
// Depends on wqsa_pkg and weighted_queue_share_allocator_assert.svh.
`default_nettype none

`include "weighted_queue_share_allocator_assert.svh"

module wqsa_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             action,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [wqsa_pkg::QUEUE_W-1:0]     granted_queue,
  input wire logic [wqsa_pkg::SLOT_W-1:0]      granted_slot,
  input wire logic [wqsa_pkg::AMOUNT_BITS-1:0] amount,
  input wire logic                             finished_now,
  input wire logic                             nothing_given,
  input wire logic                             last
);

  // Whole result record as one vector
  logic [wqsa_pkg::QUEUE_W+wqsa_pkg::SLOT_W+wqsa_pkg::AMOUNT_BITS+2:0] out_rec;

  assign out_rec = {granted_queue, granted_slot, amount, finished_now, nothing_given, last};

  // Stalled result transfer holds its record
  `WQSA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_rec))

  // Empty record closes its tick and carries nothing
  `WQSA_ASSERT(a_empty_rec, out_valid && nothing_given |-> last && amount == '0 && !finished_now)

  // Every real grant moves at least one unit
  `WQSA_ASSERT(a_grant_nonzero, out_valid && !nothing_given |-> amount != '0)

  // A tick transfer occupies the block on the following cycle
  `WQSA_ASSERT(a_tick_busy, in_valid && in_ready && action |=> !in_ready)

  // No result is offered right after reset
  `WQSA_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid)

endmodule

bind weighted_queue_share_allocator wqsa_checker u_wqsa_checker (.*);

`default_nettype wire
